// File: rtl/core/psu_pkg.sv
package psu_pkg;

  // Fixed widths of the stream fields and the register file.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SW_W       = 5;
  localparam int unsigned SPF_W      = 20;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // At most this many samples leave for one input byte.
  localparam int unsigned RUN_MAX = 8;
  localparam int unsigned RUN_W   = $clog2(RUN_MAX);
  localparam logic [RUN_W-1:0] RUN_LAST = RUN_W'(RUN_MAX - 1);

  // Register indexes, decoded from paddr[2].
  localparam logic REG_SAMPLE_WIDTH      = 1'b0;
  localparam logic REG_SAMPLES_PER_FRAME = 1'b1;

  localparam logic [SW_W-1:0]  SAMPLE_WIDTH_RST      = SW_W'(11);
  localparam logic [SPF_W-1:0] SAMPLES_PER_FRAME_RST = SPF_W'(307200);

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              frame_start;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_of_run;
    logic                frame_end;
  } out_item_t;

  typedef struct packed {
    logic [SW_W-1:0]  sample_width;
    logic [SPF_W-1:0] samples_per_frame;
  } cfg_t;

endpackage

// File: rtl/core/psu_cfg_regs.sv
module psu_cfg_regs import psu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [SW_W-1:0]  sample_width_q,      sample_width_d;
  logic [SPF_W-1:0] samples_per_frame_q, samples_per_frame_d;
  logic             reg_idx;
  logic             wr_en;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    sample_width_d      = sample_width_q;
    samples_per_frame_d = samples_per_frame_q;
    if (wr_en) begin
      case (reg_idx)
        REG_SAMPLE_WIDTH:      sample_width_d      = pwdata[SW_W-1:0];
        REG_SAMPLES_PER_FRAME: samples_per_frame_d = pwdata[SPF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SAMPLE_WIDTH:      prdata = APB_DATA_W'(sample_width_q);
      REG_SAMPLES_PER_FRAME: prdata = APB_DATA_W'(samples_per_frame_q);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_width_q      <= SAMPLE_WIDTH_RST;
      samples_per_frame_q <= SAMPLES_PER_FRAME_RST;
    end else begin
      sample_width_q      <= sample_width_d;
      samples_per_frame_q <= samples_per_frame_d;
    end
  end

  assign cfg_o.sample_width      = sample_width_q;
  assign cfg_o.samples_per_frame = samples_per_frame_q;

endmodule

// File: rtl/core/psu_in_buf.sv
module psu_in_buf import psu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     buf_valid_o,
  output in_item_t buf_data_o,
  input  logic     consume_i
);

  logic     valid_q, valid_d;
  in_item_t data_q;
  logic     load;

  // The buffer refills in the same cycle that the unpacker drains it.
  assign in_stall_o = valid_q && !consume_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign buf_valid_o = valid_q;
  assign buf_data_o  = data_q;

endmodule

// File: rtl/core/psu_unpack.sv
module psu_unpack import psu_pkg::*; #(
  parameter int unsigned MAX_SAMPLE_WIDTH = 16,
  parameter int unsigned FRAME_COUNT_BITS = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      buf_valid_i,
  input  in_item_t  buf_data_i,
  output logic      consume_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AccBits = MAX_SAMPLE_WIDTH + BYTE_W;
  localparam int unsigned HeldW   = $clog2(AccBits + 1);

  logic [AccBits-1:0]          acc_q, acc_d;
  logic [HeldW-1:0]            held_q, held_d;
  logic [FRAME_COUNT_BITS-1:0] done_q, done_d;
  logic [RUN_W-1:0]            run_q, run_d;
  logic                        active_q, active_d;
  logic                        out_valid_q, out_valid_d;
  out_item_t                   out_q, out_d;

  logic [HeldW-1:0]            raw_w, w_eff;
  logic [FRAME_COUNT_BITS-1:0] lim;

  logic [AccBits-1:0]          acc_base, acc_in;
  logic [HeldW-1:0]            held_base, held_in;
  logic [HeldW:0]              held_sum;
  logic [FRAME_COUNT_BITS-1:0] done_base;
  logic                        drop;

  logic [AccBits-1:0]          src_acc, shifted, mask;
  logic [HeldW-1:0]            src_held, held_next;
  logic [FRAME_COUNT_BITS-1:0] src_done, done_next;
  logic [RUN_W-1:0]            src_run;
  logic                        frame_end, last;
  logic                        out_free, emit, consume;

  // Effective sample width and frame limit.
  assign raw_w = HeldW'(cfg_i.sample_width);
  always_comb begin
    if (raw_w == '0) begin
      w_eff = HeldW'(1);
    end else if (raw_w > HeldW'(MAX_SAMPLE_WIDTH)) begin
      w_eff = HeldW'(MAX_SAMPLE_WIDTH);
    end else begin
      w_eff = raw_w;
    end
  end
  assign lim = (|(cfg_i.samples_per_frame >> FRAME_COUNT_BITS)) ? '1
             : FRAME_COUNT_BITS'(cfg_i.samples_per_frame);

  // Absorb the buffered byte, after an optional frame-start clear.
  assign acc_base  = buf_data_i.frame_start ? '0 : acc_q;
  assign held_base = buf_data_i.frame_start ? '0 : held_q;
  assign done_base = buf_data_i.frame_start ? '0 : done_q;
  assign drop      = done_base >= lim;
  assign acc_in    = {acc_base[AccBits-BYTE_W-1:0], buf_data_i.data_byte};
  assign held_sum  = {1'b0, held_base} + (HeldW + 1)'(BYTE_W);
  assign held_in   = (held_sum > (HeldW + 1)'(AccBits)) ? HeldW'(AccBits)
                   : held_sum[HeldW-1:0];

  // One sample is taken either from the state of a running byte or from
  // the freshly absorbed byte.
  assign src_acc  = active_q ? acc_q  : acc_in;
  assign src_held = active_q ? held_q : held_in;
  assign src_done = active_q ? done_q : done_base;
  assign src_run  = active_q ? run_q  : '0;

  assign held_next = src_held - w_eff;
  assign mask      = (AccBits'(1) << w_eff) - AccBits'(1);
  assign shifted   = (src_acc >> held_next) & mask;
  assign done_next = src_done + FRAME_COUNT_BITS'(1);
  assign frame_end = done_next == lim;
  assign last      = (src_run == RUN_LAST) || (held_next < w_eff) || frame_end;

  assign out_free = !out_valid_q || !out_stall_i;
  assign consume  = out_free && !active_q && buf_valid_i;
  assign emit     = out_free && (active_q ||
                    (buf_valid_i && !drop && (held_in >= w_eff)));

  always_comb begin
    acc_d       = acc_q;
    held_d      = held_q;
    done_d      = done_q;
    run_d       = run_q;
    active_d    = active_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      acc_d             = src_acc;
      held_d            = held_next;
      done_d            = done_next;
      run_d             = last ? '0 : src_run + RUN_W'(1);
      active_d          = !last;
      out_d.sample      = shifted[SAMPLE_W-1:0];
      out_d.last_of_run = last;
      out_d.frame_end   = frame_end;
    end else if (consume) begin
      acc_d  = drop ? acc_base  : acc_in;
      held_d = drop ? held_base : held_in;
      done_d = done_base;
    end
    if (out_free) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      held_q      <= '0;
      done_q      <= '0;
      run_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      held_q      <= held_d;
      done_q      <= done_d;
      run_q       <= run_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign consume_o   = consume;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The accumulator never claims more bits than it holds.
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HeldW'(AccBits))
    else $error("bit count exceeds accumulator width");

  // Every emitted sample advances the frame counter by exactly one; a frame start clears it first.
  a_done_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (done_q == FRAME_COUNT_BITS'($past(done_q) + FRAME_COUNT_BITS'(1)) ||
              $past(!active_q && buf_data_i.frame_start)))
    else $error("frame counter out of step with emitted samples");

  // The per-byte sample counter is cleared whenever no byte is running.
  a_run_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> run_q == '0)
    else $error("run counter left over from a finished byte");

  // A new byte is never taken while the result register is blocked.
  a_no_take_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !consume_o)
    else $error("byte consumed while result register is stalled");

endmodule

// File: rtl/core/packed_sample_unpacker_core.sv
// Channel  | Direction | Handshake                      | Payload
// ---------+-----------+--------------------------------+---------------------------------
// in       | input     | in_valid_i / in_stall_o        | in_data_i  (data_byte, frame_start)
// out      | output    | out_valid_o / out_stall_i      | out_data_o (sample, last_of_run,
//          |           |                                |             frame_end)
// cfg      | input     | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// A transfer on the input channel lands in an input register; the unpacker then absorbs it and
// places its first sample in the result register. A byte that yields n samples occupies the
// single sample extractor until all n are out (n is at most 8); bytes that yield zero or one
// sample are taken at one per cycle while the output is not stalled.
// Reset clears the accumulator, the bit count, the frame counter and the handshakes, and
// restores the register defaults; no clearing pass follows.
// A stall on the output holds the result register and, through it, the input register.

module packed_sample_unpacker_core import psu_pkg::*; #(
  parameter int unsigned MAX_SAMPLE_WIDTH = 16,
  parameter int unsigned FRAME_COUNT_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg;
  logic     buf_valid;
  in_item_t buf_data;
  logic     consume;

  // Register file: sample_width at byte address 0, samples_per_frame at 4.
  psu_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register. It refills in the same cycle that it is drained, so a
  // steady stream of bytes sees no bubbles.
  psu_in_buf u_in_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .buf_valid_o (buf_valid),
    .buf_data_o  (buf_data),
    .consume_i   (consume)
  );

  // Bit accumulator, frame counter and result register. The byte is shifted
  // in and the oldest sample is cut out with a barrel shift in the same cycle;
  // further samples of the same byte follow one per cycle unless stalled.
  psu_unpack #(
    .MAX_SAMPLE_WIDTH (MAX_SAMPLE_WIDTH),
    .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
  ) u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .buf_valid_i (buf_valid),
    .buf_data_i  (buf_data),
    .consume_o   (consume),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/sv/packed_sample_unpacker_core_tb.sv
`timescale 1ns / 1ps

module packed_sample_unpacker_core_tb;
  import psu_pkg::*;

  // Widths of the unpacker as instantiated with default parameters.
  localparam int unsigned SAMPLE_MAX_W = 16;
  localparam int unsigned ACC_W        = SAMPLE_MAX_W + BYTE_W;

  // Cycles allowed after the last sample before a register write or the end of the run.
  // The two-stage pipeline may still be absorbing a byte that produced no sample.
  localparam int unsigned IDLE_TAIL  = 12;
  localparam int unsigned END_TAIL   = 20;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_BYTES = 430;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  packed_sample_unpacker_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the unpacker state and of its two registers. The register copies are
  // updated at the same point in time as the hardware registers are written.
  logic [SW_W-1:0]  cfg_width     = SAMPLE_WIDTH_RST;
  logic [SPF_W-1:0] cfg_frame_len = SAMPLES_PER_FRAME_RST;
  logic [ACC_W-1:0] acc_bits      = '0;
  int unsigned      held_bits     = 0;
  logic [SPF_W-1:0] frame_count   = '0;

  // Samples that the mirror has produced and the output channel has not yet delivered.
  out_item_t        expected_samples[$];
  out_item_t        oldest_sample;

  int unsigned      errors       = 0;
  int unsigned      cycle_count  = 0;
  int unsigned      bytes_sent   = 0;
  int unsigned      burst_left   = 0;
  int unsigned      stall_mode   = 0;
  int unsigned      stall_hold   = 0;

  // A width of zero behaves as one, and anything above the maximum behaves as the maximum.
  function automatic int unsigned eff_width(input logic [SW_W-1:0] w);
    if (w == 0) return 1;
    if (w > SAMPLE_MAX_W) return SAMPLE_MAX_W;
    return 32'(w);
  endfunction

  // Absorbs one accepted byte into the mirror and queues the samples it releases.
  // Returns 0 when the byte is dropped because the frame is already complete.
  function automatic bit unpack_byte(input in_item_t item);
    int unsigned      w;
    int unsigned      n;
    logic [31:0]      field_mask;
    out_item_t        run[RUN_MAX];
    w = eff_width(cfg_width);
    field_mask = (32'd1 << w) - 32'd1;
    n = 0;
    if (item.frame_start) begin
      acc_bits    = '0;
      held_bits   = 0;
      frame_count = '0;
    end
    if (frame_count >= cfg_frame_len) return 1'b0;
    acc_bits  = {acc_bits[ACC_W-BYTE_W-1:0], item.data_byte};
    held_bits = (held_bits + BYTE_W > ACC_W) ? ACC_W : held_bits + BYTE_W;
    while (n < RUN_MAX && held_bits >= w && frame_count < cfg_frame_len) begin
      held_bits = held_bits - w;
      frame_count = frame_count + SPF_W'(1);
      run[n].sample      = SAMPLE_W'((32'(acc_bits) >> held_bits) & field_mask);
      run[n].last_of_run = 1'b0;
      run[n].frame_end   = (frame_count == cfg_frame_len);
      n++;
    end
    if (n > 0) run[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_samples.push_back(run[i]);
    return 1'b1;
  endfunction

  // Sends one byte over the input channel. The sender works in bursts: when a burst is
  // used up it may drop valid before the next one starts. Valid only falls between
  // transfers, so a stalled payload never changes.
  task automatic send_byte(input logic [BYTE_W-1:0] value, input logic start);
    in_item_t    item;
    int unsigned gap_len;
    item.data_byte   = value;
    item.frame_start = start;
    if (burst_left == 0) begin
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_len != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // The transfer happened at this edge; the mirror sees the byte in the same order.
    void'(unpack_byte(item));
    bytes_sent++;
    burst_left--;
  endtask

  // Brings the unpacker to rest: input idle, every queued sample delivered, and a
  // further wait so that a byte that produced nothing has left the pipeline.
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (IDLE_TAIL) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; the register changes at the access edge.
  task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_SAMPLE_WIDTH) begin
      cfg_width = value[SW_W-1:0];
    end else begin
      cfg_frame_len = value[SPF_W-1:0];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // APB read of one register, compared with the mirrored value.
  task automatic check_reg(input logic idx);
    logic [APB_DATA_W-1:0] want;
    want = (idx == REG_SAMPLE_WIDTH) ? APB_DATA_W'(cfg_width) : APB_DATA_W'(cfg_frame_len);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      $display("%0t: register %0d read: expected %h, actual %h", $time, idx, want, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // The registers must come out of reset with their documented defaults.
  task automatic test_reset_values();
    check_reg(REG_SAMPLE_WIDTH);
    check_reg(REG_SAMPLES_PER_FRAME);
  endtask

  // A short frame at the default width of 11 bits, with all-ones and all-zeros bytes.
  task automatic test_default_width();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    settle();
  endtask

  // Widest and narrowest samples, including the register values that get clamped.
  // A one-bit width turns each byte into the largest run of eight samples.
  task automatic test_width_extremes();
    write_reg(REG_SAMPLES_PER_FRAME, 32'd1000);
    write_reg(REG_SAMPLE_WIDTH, 32'd16);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    settle();
    write_reg(REG_SAMPLE_WIDTH, 32'd1);
    send_byte(8'hA5, 1'b1);
    settle();
    write_reg(REG_SAMPLE_WIDTH, 32'd0);
    check_reg(REG_SAMPLE_WIDTH);
    send_byte(8'h3C, 1'b0);
    settle();
    write_reg(REG_SAMPLE_WIDTH, 32'd31);
    check_reg(REG_SAMPLE_WIDTH);
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b0);
    settle();
  endtask

  // Shrinking the width while bits are held: the next byte releases at most eight
  // samples and the remaining bits stay in the accumulator for later bytes.
  task automatic test_width_shrink();
    write_reg(REG_SAMPLE_WIDTH, 32'd13);
    send_byte(8'hAB, 1'b1);
    send_byte(8'hCD, 1'b0);
    send_byte(8'hEF, 1'b0);
    settle();
    write_reg(REG_SAMPLE_WIDTH, 32'd1);
    send_byte(8'h5A, 1'b0);
    settle();
  endtask

  // Frame length handling: a one-sample frame followed by a dropped byte and a restart,
  // an empty frame that drops everything, and the largest frame length.
  task automatic test_frame_limits();
    write_reg(REG_SAMPLE_WIDTH, 32'd8);
    write_reg(REG_SAMPLES_PER_FRAME, 32'd1);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b1);
    settle();
    write_reg(REG_SAMPLES_PER_FRAME, 32'd0);
    send_byte(8'h44, 1'b1);
    send_byte(8'h55, 1'b0);
    settle();
    write_reg(REG_SAMPLES_PER_FRAME, 32'hFFFFF);
    write_reg(REG_SAMPLE_WIDTH, 32'd4);
    check_reg(REG_SAMPLES_PER_FRAME);
    send_byte(8'h9F, 1'b1);
    settle();
  endtask

  // Random settings, each followed by a few frames of random bytes. Most frames are
  // well formed: a frame start, enough bytes to finish the frame, and a few trailing
  // bytes that must be dropped. Some frames are cut short, some carry stray frame
  // starts, and some omit the opening frame start. Sending stops once the byte budget
  // is used up.
  task automatic test_random_frames();
    int unsigned      goal;
    int unsigned      nbytes;
    int unsigned      shape;
    logic [SW_W-1:0]  pick_width;
    logic [SPF_W-1:0] pick_len;
    logic [31:0]      junk;
    logic             start;
    goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < goal) begin
      settle();
      case ($urandom_range(0, 9))
        0:       pick_width = '0;
        1:       pick_width = SW_W'($urandom_range(SAMPLE_MAX_W + 1, 31));
        2:       pick_width = SW_W'(SAMPLE_MAX_W);
        3:       pick_width = SW_W'(1);
        default: pick_width = SW_W'($urandom_range(1, SAMPLE_MAX_W));
      endcase
      case ($urandom_range(0, 9))
        0:       pick_len = '0;
        1:       pick_len = '1;
        2:       pick_len = SPF_W'(1);
        default: pick_len = SPF_W'($urandom_range(2, 40));
      endcase
      // Bits above each field are sometimes set; the registers must ignore them.
      junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      if ($urandom_range(0, 1)) begin
        write_reg(REG_SAMPLE_WIDTH, (junk & ~32'h1F) | 32'(pick_width));
        write_reg(REG_SAMPLES_PER_FRAME, (junk & ~32'hFFFFF) | 32'(pick_len));
      end else begin
        write_reg(REG_SAMPLES_PER_FRAME, (junk & ~32'hFFFFF) | 32'(pick_len));
        write_reg(REG_SAMPLE_WIDTH, (junk & ~32'h1F) | 32'(pick_width));
      end
      if ($urandom_range(0, 3) == 0) begin
        check_reg(REG_SAMPLE_WIDTH);
        check_reg(REG_SAMPLES_PER_FRAME);
      end
      repeat ($urandom_range(1, 4)) begin
        nbytes = (int'(pick_len) * eff_width(pick_width) + 7) / 8;
        if (nbytes == 0) nbytes = $urandom_range(1, 4);
        if (nbytes > 64) nbytes = $urandom_range(8, 64);
        shape = $urandom_range(0, 9);
        if (shape == 0) nbytes = $urandom_range(1, nbytes);
        nbytes += $urandom_range(0, 3);
        for (int k = 0; k < nbytes; k++) begin
          if (bytes_sent >= goal) break;
          if (k == 0) start = ($urandom_range(0, 9) != 0);
          else start = (shape == 1) && ($urandom_range(0, 5) == 0);
          send_byte(8'($urandom_range(0, 255)), start);
        end
      end
    end
    settle();
  endtask

  // The receiver stalls on a pattern that changes every so often: no stalls, light or
  // heavy random stalls, or a fixed two-in-five rhythm.
  always @(posedge clk_i) begin
    if (stall_hold == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_hold <= $urandom_range(20, 200);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 9) < 6);
      default: out_stall_i <= ((cycle_count % 5) < 2);
    endcase
  end

  // Every delivered sample is compared with the oldest one the mirror produced.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: sample with none expected: expected nothing, actual %h",
                 $time, out_data_o);
        errors++;
      end else begin
        oldest_sample = expected_samples.pop_front();
        if (out_data_o.sample !== oldest_sample.sample) begin
          $display("%0t: sample: expected %h, actual %h",
                   $time, oldest_sample.sample, out_data_o.sample);
          errors++;
        end
        if (out_data_o.last_of_run !== oldest_sample.last_of_run) begin
          $display("%0t: last_of_run: expected %b, actual %b",
                   $time, oldest_sample.last_of_run, out_data_o.last_of_run);
          errors++;
        end
        if (out_data_o.frame_end !== oldest_sample.frame_end) begin
          $display("%0t: frame_end: expected %b, actual %b",
                   $time, oldest_sample.frame_end, out_data_o.frame_end);
          errors++;
        end
      end
    end
  end

  // Guard against a hang anywhere in the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_default_width();
    test_width_extremes();
    test_width_shrink();
    test_frame_limits();
    test_random_frames();

    // Anything still queued here means samples went missing.
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (END_TAIL) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
